[rtl/core/key_matrix_press_tracker_defines.svh]
// Assertion macros for the key matrix press tracker.
// Included by RTL files that carry concurrent checks; needs no other file.
`ifndef KEY_MATRIX_PRESS_TRACKER_DEFINES_SVH
`define KEY_MATRIX_PRESS_TRACKER_DEFINES_SVH
`ifndef SYNTH
// prop must hold at every clock edge outside reset
`define KMPT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("kmpt assertion failed");
// expr must never be true outside reset
`define KMPT_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("kmpt forbidden condition seen");
`else
`define KMPT_ASSERT(lbl, prop)
`define KMPT_NEVER(lbl, expr)
`endif
`endif

[rtl/core/kmpt_pkg.sv]
// Shared types and constants for the key matrix press tracker.
// No dependencies.
package kmpt_pkg;

	localparam int ROWS  = 8;
	localparam int COLS  = 16;
	localparam int SLOTS = 8;

	localparam int KEYS   = ROWS * COLS;
	localparam int CODE_W = (KEYS > 1) ? $clog2(KEYS) : 1;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam int ROW_W   = 3;
	localparam int COL_W   = 4;
	localparam int CNT_W   = 8;
	localparam int UPG_W   = 7;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	// register index decoded from paddr[APB_AW-1:2]
	localparam logic REG_UPGRADE_KEY = 1'b0;

	typedef enum logic [2:0] {
		EV_NONE      = 3'd0,
		EV_NEW       = 3'd1,
		EV_PROMOTE   = 3'd2,
		EV_HELD_REL  = 3'd3,
		EV_EARLY_REL = 3'd4
	} event_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             pressed;
		logic             scan_start;
	} sample_t;

	typedef struct packed {
		event_t           event_res;
		logic             changed;
		logic [CNT_W-1:0] pressed_count;
		logic             boot_request;
		logic             insert_dropped;
	} result_t;

endpackage

[rtl/core/key_matrix_press_tracker.sv]
// Key matrix press tracker: top level, the only module of the block.
// Depends on kmpt_pkg and key_matrix_press_tracker_defines.svh.
//
// One matrix sample is taken as a transaction when start is high and busy is
// low. The block then walks its two slot lists (just-pressed and held) with a
// single slot compare unit, one slot index per cycle, and then applies the
// list update in its update state. The result appears on the result port for
// exactly one cycle with done high; busy drops in that same cycle, so the next
// sample is taken at the edge that ends the done cycle. The receiver cannot
// stall: a result that is not taken in its done cycle is gone. The slot
// compare sequencer keeps the block busy, so it takes no new sample until it
// is through with the last one. The upgrade key code register sits at byte
// address 0 of the APB port; writes are meant to happen only while the block
// is idle.
`include "key_matrix_press_tracker_defines.svh"

module key_matrix_press_tracker (
	input  logic                            clk,
	input  logic                            arst_n,
	// sample command channel
	input  logic                            start,
	input  kmpt_pkg::sample_t               cmd,
	output logic                            busy,
	// result channel, one-cycle strobe
	output logic                            done,
	output kmpt_pkg::result_t               result,
	// configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [kmpt_pkg::APB_AW-1:0]     paddr,
	input  logic [kmpt_pkg::APB_DW-1:0]     pwdata,
	output logic [kmpt_pkg::APB_DW-1:0]     prdata,
	output logic                            pready
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_UPDATE
	} state_t;

	state_t state_q;

	// accepted transaction
	kmpt_pkg::sample_t                 smp_q;
	logic [kmpt_pkg::CODE_W-1:0]       code_q;
	logic                              in_range_q;

	// search results gathered by the compare unit
	logic [kmpt_pkg::SLOT_W-1:0]       idx_q;
	logic                              fhit_q, hhit_q, ffree_q, hfree_q;
	logic [kmpt_pkg::SLOT_W-1:0]       fhit_pos_q, hhit_pos_q, ffree_pos_q, hfree_pos_q;

	// slot lists
	logic [kmpt_pkg::SLOTS-1:0]        fresh_vld_q, held_vld_q;
	logic [kmpt_pkg::CODE_W-1:0]       fresh_code_q [kmpt_pkg::SLOTS];
	logic [kmpt_pkg::CODE_W-1:0]       held_code_q  [kmpt_pkg::SLOTS];

	logic [kmpt_pkg::CNT_W-1:0]        count_q;
	logic [kmpt_pkg::UPG_W-1:0]        upg_q;

	logic                              done_q;
	kmpt_pkg::result_t                 result_q;

	// handshake decode
	logic accept;
	logic cfg_wr;
	logic cfg_sel_upg;

	// shared slot compare unit: looks at slot idx_q of both lists
	logic f_match, h_match, f_free, h_free;

	// update-cycle decisions
	logic [kmpt_pkg::CNT_W-1:0] cnt_base;
	logic [kmpt_pkg::CNT_W-1:0] cnt_next;
	logic                       boot_hit;
	logic [kmpt_pkg::CODE_W-1:0] code_in;
	logic                       range_in;

	// registered event is one that flags a change
	logic                       change_event;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = result_q;

	// APB: zero wait states
	assign pready      = 1'b1;
	assign cfg_sel_upg = (paddr[kmpt_pkg::APB_AW-1:2] == kmpt_pkg::REG_UPGRADE_KEY);
	assign cfg_wr      = psel && penable && pwrite && pready;
	assign prdata      = cfg_sel_upg ?
		{{(kmpt_pkg::APB_DW - kmpt_pkg::UPG_W){1'b0}}, upg_q} : '0;

	// key code of the incoming sample
	assign range_in = (int'(cmd.row) < kmpt_pkg::ROWS) && (int'(cmd.col) < kmpt_pkg::COLS);
	assign code_in  = kmpt_pkg::CODE_W'(int'(cmd.row) * kmpt_pkg::COLS + int'(cmd.col));

	assign f_match = fresh_vld_q[idx_q] && (fresh_code_q[idx_q] == code_q);
	assign h_match = held_vld_q[idx_q]  && (held_code_q[idx_q]  == code_q);
	assign f_free  = !fresh_vld_q[idx_q];
	assign h_free  = !held_vld_q[idx_q];

	assign cnt_base = smp_q.scan_start ? '0 : count_q;
	assign cnt_next = (cnt_base == {kmpt_pkg::CNT_W{1'b1}}) ? cnt_base :
		cnt_base + kmpt_pkg::CNT_W'(1);
	assign boot_hit = (32'(code_q) == 32'(upg_q));

	assign change_event = (result_q.event_res == kmpt_pkg::EV_NEW) ||
		(result_q.event_res == kmpt_pkg::EV_HELD_REL) ||
		(result_q.event_res == kmpt_pkg::EV_EARLY_REL);

	// control, valid bits and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			fhit_q      <= 1'b0;
			hhit_q      <= 1'b0;
			ffree_q     <= 1'b0;
			hfree_q     <= 1'b0;
			fresh_vld_q <= '0;
			held_vld_q  <= '0;
			count_q     <= '0;
			upg_q       <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_wr && cfg_sel_upg) begin
				upg_q <= pwdata[kmpt_pkg::UPG_W-1:0];
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SEARCH;
						idx_q   <= '0;
						fhit_q  <= 1'b0;
						hhit_q  <= 1'b0;
						ffree_q <= 1'b0;
						hfree_q <= 1'b0;
					end
				end
				ST_SEARCH: begin
					// keep only the lowest match and the lowest free slot
					if (f_match && !fhit_q) begin
						fhit_q <= 1'b1;
					end
					if (h_match && !hhit_q) begin
						hhit_q <= 1'b1;
					end
					if (f_free && !ffree_q) begin
						ffree_q <= 1'b1;
					end
					if (h_free && !hfree_q) begin
						hfree_q <= 1'b1;
					end
					if (32'(idx_q) == kmpt_pkg::SLOTS - 1) begin
						state_q <= ST_UPDATE;
					end else begin
						idx_q <= idx_q + kmpt_pkg::SLOT_W'(1);
					end
				end
				ST_UPDATE: begin
					state_q                      <= ST_IDLE;
					done_q                       <= 1'b1;
					result_q.event_res           <= kmpt_pkg::EV_NONE;
					result_q.changed             <= 1'b0;
					result_q.boot_request        <= 1'b0;
					result_q.insert_dropped      <= 1'b0;
					result_q.pressed_count       <= cnt_base;
					count_q                      <= cnt_base;
					if (in_range_q) begin
						if (smp_q.pressed) begin
							result_q.boot_request  <= boot_hit;
							result_q.pressed_count <= cnt_next;
							count_q                <= cnt_next;
							if (fhit_q) begin
								// second pressed sample: move to held list
								fresh_vld_q[fhit_pos_q] <= 1'b0;
								result_q.event_res      <= kmpt_pkg::EV_PROMOTE;
								if (hfree_q) begin
									held_vld_q[hfree_pos_q] <= 1'b1;
								end else begin
									result_q.insert_dropped <= 1'b1;
								end
							end else if (!hhit_q) begin
								result_q.event_res <= kmpt_pkg::EV_NEW;
								result_q.changed   <= 1'b1;
								if (ffree_q) begin
									fresh_vld_q[ffree_pos_q] <= 1'b1;
								end else begin
									result_q.insert_dropped <= 1'b1;
								end
							end
						end else begin
							if (hhit_q) begin
								held_vld_q[hhit_pos_q] <= 1'b0;
								result_q.event_res     <= kmpt_pkg::EV_HELD_REL;
								result_q.changed       <= 1'b1;
							end else if (fhit_q) begin
								fresh_vld_q[fhit_pos_q] <= 1'b0;
								result_q.event_res      <= kmpt_pkg::EV_EARLY_REL;
								result_q.changed        <= 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload: sample, slot positions and slot codes
	always_ff @(posedge clk) begin
		if (accept) begin
			smp_q      <= cmd;
			code_q     <= code_in;
			in_range_q <= range_in;
		end
		if (state_q == ST_SEARCH) begin
			if (f_match && !fhit_q) begin
				fhit_pos_q <= idx_q;
			end
			if (h_match && !hhit_q) begin
				hhit_pos_q <= idx_q;
			end
			if (f_free && !ffree_q) begin
				ffree_pos_q <= idx_q;
			end
			if (h_free && !hfree_q) begin
				hfree_pos_q <= idx_q;
			end
		end
		if (state_q == ST_UPDATE && in_range_q && smp_q.pressed) begin
			if (fhit_q) begin
				if (hfree_q) begin
					held_code_q[hfree_pos_q] <= code_q;
				end
			end else if (!hhit_q && ffree_q) begin
				fresh_code_q[ffree_pos_q] <= code_q;
			end
		end
	end

	// checks
	`KMPT_NEVER(a_done_while_busy, done_q && busy)
	`KMPT_ASSERT(a_accept_starts_scan, accept |=> (state_q == ST_SEARCH) && (idx_q == '0))
	`KMPT_ASSERT(a_changed_matches_event, done_q |-> (result_q.changed == change_event))
	`KMPT_ASSERT(a_done_after_update, done_q |-> ($past(state_q) == ST_UPDATE))

endmodule
